[src/apts_pkg.sv]
`timescale 1ns / 1ps

package apts_pkg;

  // item kinds
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // result codes
  localparam logic [2:0] STAT_IDLE     = 3'd0;
  localparam logic [2:0] STAT_RAN      = 3'd1;
  localparam logic [2:0] STAT_FINISHED = 3'd2;
  localparam logic [2:0] STAT_ADDED    = 3'd3;
  localparam logic [2:0] STAT_REJECTED = 3'd4;

  localparam logic [7:0] DECR_RESET = 8'd1;

  // one task slot as held in the table memory
  typedef struct packed {
    logic [7:0]         label;
    logic signed [15:0] prio;
    logic [15:0]        rem;
    logic [31:0]        arrival;
    logic [31:0]        seq;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EXEC
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } stat_t;

endpackage

[src/apts_ctrl.sv]
`timescale 1ns / 1ps

module apts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  apts_pkg::stat_t stat,
  output apts_pkg::cmd_t  cmd,
  output logic            busy
);

  apts_pkg::state_t state;
  apts_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= apts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      apts_pkg::S_IDLE: begin
        if (start) state_next = apts_pkg::S_SCAN;
      end
      apts_pkg::S_SCAN: begin
        if (stat.last) state_next = apts_pkg::S_DRAIN;
      end
      apts_pkg::S_DRAIN: begin
        state_next = apts_pkg::S_EXEC;
      end
      apts_pkg::S_EXEC: begin
        state_next = apts_pkg::S_IDLE;
      end
      default: begin
        state_next = apts_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      apts_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      apts_pkg::S_SCAN: begin
        cmd.rd = 1'b1;
      end
      apts_pkg::S_DRAIN: begin
        cmd = '0;
      end
      apts_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[src/apts_dp.sv]
`timescale 1ns / 1ps

module apts_dp #(
  parameter int NUM_TASKS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  apts_pkg::cmd_t     cmd,
  output apts_pkg::stat_t    stat,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               mode,
  input  logic [7:0]         task_id,
  input  logic [15:0]        service_time,
  input  logic signed [15:0] priority_req,
  output logic               done,
  output logic [2:0]         status,
  output logic [7:0]         ran_task,
  output logic [15:0]        remaining,
  output logic [31:0]        finish_time,
  output logic [31:0]        turnaround
);

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  // task table
  apts_pkg::entry_t table_mem [NUM_TASKS];
  apts_pkg::entry_t rd_q;
  logic [NUM_TASKS-1:0] valid;

  logic [7:0]  decr;
  logic [31:0] cur_time;
  logic [31:0] ins_cnt;

  // latched request
  logic               mode_q;
  logic [7:0]         label_q;
  logic [15:0]        svc_q;
  logic signed [15:0] prio_q;

  // scan
  logic [IDX_W-1:0] addr;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_en;
  logic             cand_valid;

  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  apts_pkg::entry_t best;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic             better;
  logic [15:0]      rem_dec;
  logic signed [16:0] prio_wide;
  logic [15:0]      prio_sat;
  logic [31:0]      fin;
  logic [31:0]      turn;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  apts_pkg::entry_t wr_data;
  logic             add_ok;

  assign stat.last = (addr == LAST_IDX);

  assign better = cand_valid &&
                  (!best_found || (rd_q.prio > best.prio) ||
                   ((rd_q.prio == best.prio) && (rd_q.seq < best.seq)));

  // aging with saturation at the most negative priority
  assign rem_dec   = best.rem - 16'd1;
  assign prio_wide = {best.prio[15], best.prio} - $signed({9'b0, decr});
  assign prio_sat  = (prio_wide[16] != prio_wide[15]) ? 16'h8000 : prio_wide[15:0];
  assign fin       = cur_time + 32'd1;
  assign turn      = cur_time + 32'd1 - best.arrival;
  assign add_ok    = free_found && (svc_q != 16'd0);

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = free_idx;
    wr_data = '{label: label_q, prio: prio_q, rem: svc_q, arrival: cur_time, seq: ins_cnt};
    if (cmd.exec) begin
      if (mode_q == apts_pkg::MODE_ADD) begin
        wr_en = add_ok;
      end else if (best_found && (rem_dec != 16'd0)) begin
        wr_en   = 1'b1;
        wr_idx  = best_idx;
        wr_data = '{label: best.label, prio: prio_sat, rem: rem_dec,
                    arrival: best.arrival, seq: ins_cnt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_idx] <= wr_data;
    end
    if (cmd.rd) begin
      rd_q <= table_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode;
      label_q <= task_id;
      svc_q   <= service_time;
      prio_q  <= priority_req;
    end
    if (cmd.rd) begin
      cmp_idx    <= addr;
      cand_valid <= valid[addr];
    end
    if (cmp_en && better) begin
      best_idx <= cmp_idx;
      best     <= rd_q;
    end
    if (cmp_en && !cand_valid && !free_found) begin
      free_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      decr       <= apts_pkg::DECR_RESET;
      cur_time   <= '0;
      ins_cnt    <= '0;
      addr       <= '0;
      cmp_en     <= 1'b0;
      best_found <= 1'b0;
      free_found <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        decr <= cfg_wdata;
      end
      cmp_en <= cmd.rd;
      done   <= cmd.exec;
      if (cmd.load) begin
        addr       <= '0;
        best_found <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.rd) begin
          addr <= addr + IDX_W'(1);
        end
        if (cmp_en && better) begin
          best_found <= 1'b1;
        end
        if (cmp_en && !cand_valid) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.exec) begin
        if (mode_q == apts_pkg::MODE_ADD) begin
          if (add_ok) begin
            valid[free_idx] <= 1'b1;
            ins_cnt         <= ins_cnt + 32'd1;
          end
        end else begin
          cur_time <= cur_time + 32'd1;
          if (best_found) begin
            if (rem_dec == 16'd0) begin
              valid[best_idx] <= 1'b0;
            end else begin
              ins_cnt <= ins_cnt + 32'd1;
            end
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status      <= apts_pkg::STAT_IDLE;
      ran_task    <= '0;
      remaining   <= '0;
      finish_time <= '0;
      turnaround  <= '0;
      if (mode_q == apts_pkg::MODE_ADD) begin
        ran_task <= label_q;
        if (add_ok) begin
          status    <= apts_pkg::STAT_ADDED;
          remaining <= svc_q;
        end else begin
          status <= apts_pkg::STAT_REJECTED;
        end
      end else if (best_found) begin
        ran_task <= best.label;
        if (rem_dec == 16'd0) begin
          status      <= apts_pkg::STAT_FINISHED;
          finish_time <= fin;
          turnaround  <= turn;
        end else begin
          status    <= apts_pkg::STAT_RAN;
          remaining <= rem_dec;
        end
      end
    end
  end

endmodule

[src/aging_priority_task_scheduler.sv]
`timescale 1ns / 1ps

// preemptive priority scheduler with aging, NUM_TASKS slots. a request is
// taken when start is high and busy is low: mode 0 adds a task (task_id,
// service_time, signed priority_req) into the lowest free slot, mode 1 is one
// time tick that runs the waiting task of highest priority for one unit (ties
// to the earliest queue entry). every request gives exactly one result, shown
// for one cycle with done high; the receiver cannot stall, so the result must
// be taken in that cycle. busy stays high through the slot scan, last compare
// and execute step, and no new request is taken while it is high. the scan
// reads one table entry per cycle through the single read port of the task
// memory. priority_decrement is written through cfg_we / cfg_wdata; the user
// must write it only while no request is in flight; the block does not check.

module aging_priority_task_scheduler #(
  parameter int NUM_TASKS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // request
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [7:0]         task_id,
  input  logic [15:0]        service_time,
  input  logic signed [15:0] priority_req,
  // priority_decrement register
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  // result
  output logic               done,
  output logic [2:0]         status,
  output logic [7:0]         ran_task,
  output logic [15:0]        remaining,
  output logic [31:0]        finish_time,
  output logic [31:0]        turnaround
);

  apts_pkg::cmd_t  cmd;
  apts_pkg::stat_t stat;

  // sequencer: idle, slot scan, last compare, execute
  apts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // task table, best/free search, aging and result register
  apts_dp #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mode         (mode),
    .task_id      (task_id),
    .service_time (service_time),
    .priority_req (priority_req),
    .done         (done),
    .status       (status),
    .ran_task     (ran_task),
    .remaining    (remaining),
    .finish_time  (finish_time),
    .turnaround   (turnaround)
  );

endmodule

[src/apts_chk.sv]
`timescale 1ns / 1ps

module apts_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [15:0] remaining,
  input logic [31:0] finish_time,
  input logic [31:0] turnaround
);

  // a taken request holds busy off further requests
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  // the result comes out as the request completes
  a_done_at_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("no result at end of request");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result repeated");

  a_times_only_on_finish: assert property (@(posedge clk) disable iff (rst)
    (done && (status != apts_pkg::STAT_FINISHED)) |->
      ((finish_time == 32'd0) && (turnaround == 32'd0)))
    else $error("finish time shown without finish");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (done && ((status == apts_pkg::STAT_REJECTED) || (status == apts_pkg::STAT_IDLE)
              || (status == apts_pkg::STAT_FINISHED))) |-> (remaining == 16'd0))
    else $error("remaining time on result without a live task");

endmodule

bind aging_priority_task_scheduler apts_chk u_apts_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .remaining   (remaining),
  .finish_time (finish_time),
  .turnaround  (turnaround)
);

[sim/aging_priority_task_scheduler_tb.sv]
`timescale 1ns / 1ps

module aging_priority_task_scheduler_tb;

  localparam int NUM_TASKS = 16;

  // one request as driven on the input ports
  typedef struct packed {
    logic               mode;
    logic [7:0]         task_id;
    logic [15:0]        svc;
    logic signed [15:0] prio;
  } request_t;

  // one result as seen on the output ports
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  task_label;
    logic [15:0] rem;
    logic [31:0] fin;
    logic [31:0] turn;
  } sched_result_t;

  // every input starts at a known value
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               mode = apts_pkg::MODE_ADD;
  logic [7:0]         task_id = '0;
  logic [15:0]        service_time = '0;
  logic signed [15:0] priority_req = '0;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_wdata = '0;
  logic               busy;
  logic               done;
  logic [2:0]         status;
  logic [7:0]         ran_task;
  logic [15:0]        remaining;
  logic [31:0]        finish_time;
  logic [31:0]        turnaround;

  // scheduler shadow: slot table, clock, insertion counter, aging step
  logic             slot_used [NUM_TASKS];
  apts_pkg::entry_t slot_tab [NUM_TASKS];
  logic [31:0]      sched_now = '0;
  logic [31:0]      next_seq = '0;
  logic [7:0]       aging_step = apts_pkg::DECR_RESET;

  request_t      req_queue[$];     // requests waiting for the driver
  sched_result_t sched_expect[$];  // results owed by the block, oldest first
  request_t      cur_req;
  sched_result_t want_res;
  logic          holding = 1'b0;   // driver has a request on the ports
  int            gap_left = 0;
  logic          idle_on = 1'b1;   // random gaps between requests on/off
  int            n_fail = 0;

  aging_priority_task_scheduler #(
    .NUM_TASKS(NUM_TASKS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .task_id     (task_id),
    .service_time(service_time),
    .priority_req(priority_req),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .status      (status),
    .ran_task    (ran_task),
    .remaining   (remaining),
    .finish_time (finish_time),
    .turnaround  (turnaround)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_TASKS; i++) slot_used[i] = 1'b0;
  end

  // apply one accepted request to the shadow and return the result it owes
  function automatic sched_result_t schedule_request(input request_t r);
    sched_result_t res;
    int            slot;
    int            pick;
    int            aged;
    logic [31:0]   now;
    res = '0;
    if (r.mode == apts_pkg::MODE_ADD) begin
      slot = -1;
      for (int i = 0; i < NUM_TASKS; i++)
        if (!slot_used[i] && slot < 0) slot = i;
      res.task_label = r.task_id;
      // full table or zero service time: rejected, nothing changes
      if (slot < 0 || r.svc == 16'd0) begin
        res.status = apts_pkg::STAT_REJECTED;
        return res;
      end
      slot_used[slot]        = 1'b1;
      slot_tab[slot].label   = r.task_id;
      slot_tab[slot].prio    = r.prio;
      slot_tab[slot].rem     = r.svc;
      slot_tab[slot].arrival = sched_now;
      slot_tab[slot].seq     = next_seq;
      next_seq               = next_seq + 32'd1;
      res.status = apts_pkg::STAT_ADDED;
      res.rem    = r.svc;
      return res;
    end
    // tick: highest priority wins, ties to the smaller sequence number
    pick = -1;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (slot_used[i] && (pick < 0 || slot_tab[i].prio > slot_tab[pick].prio ||
          (slot_tab[i].prio == slot_tab[pick].prio &&
           slot_tab[i].seq < slot_tab[pick].seq)))
        pick = i;
    end
    now       = sched_now;
    sched_now = sched_now + 32'd1;
    if (pick < 0) begin
      res.status = apts_pkg::STAT_IDLE;
      return res;
    end
    slot_tab[pick].rem = slot_tab[pick].rem - 16'd1;
    res.task_label     = slot_tab[pick].label;
    if (slot_tab[pick].rem == 16'd0) begin
      slot_used[pick] = 1'b0;
      res.status = apts_pkg::STAT_FINISHED;
      res.fin    = now + 32'd1;
      res.turn   = res.fin - slot_tab[pick].arrival;
      return res;
    end
    // aging, saturating at the most negative priority
    aged = int'(slot_tab[pick].prio) - int'(aging_step);
    if (aged < -32768) aged = -32768;
    slot_tab[pick].prio = aged[15:0];
    slot_tab[pick].seq  = next_seq;
    next_seq            = next_seq + 32'd1;
    res.status = apts_pkg::STAT_RAN;
    res.rem    = slot_tab[pick].rem;
    return res;
  endfunction

  // mostly back to back, some short pauses, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(20, 4);
    return $urandom_range(80, 30);
  endfunction

  // short jobs so that tasks finish; zero now and then as a bad request
  function automatic logic [15:0] pick_service();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'd0;
    if (r < 78) return 16'($urandom_range(3, 1));
    if (r < 97) return 16'($urandom_range(12, 4));
    return 16'($urandom_range(60, 13));
  endfunction

  // small spread around zero gives ties; extremes and full range too
  function automatic logic signed [15:0] pick_prio();
    int v;
    case ($urandom_range(9))
      0: v = 32767;
      1: v = -32768;
      2: v = 32767 - int'($urandom_range(300));
      3: v = -32768 + int'($urandom_range(300));
      4, 5: v = int'($urandom_range(65535));
      default: v = int'($urandom_range(4)) - 2;
    endcase
    return v[15:0];
  endfunction

  task automatic push_add(input logic [7:0] id, input logic [15:0] svc,
                          input logic signed [15:0] prio);
    request_t r;
    r.mode    = apts_pkg::MODE_ADD;
    r.task_id = id;
    r.svc     = svc;
    r.prio    = prio;
    req_queue.push_back(r);
  endtask

  // task_id, service_time and priority are don't-care on a tick
  task automatic push_tick();
    request_t r;
    r.mode    = apts_pkg::MODE_TICK;
    r.task_id = 8'($urandom_range(255));
    r.svc     = 16'($urandom_range(65535));
    r.prio    = 16'($urandom_range(65535));
    req_queue.push_back(r);
  endtask

  // bursts of adds followed by bursts of ticks
  task automatic queue_traffic(input int n_items, input int tick_max);
    int made;
    int k;
    made = 0;
    while (made < n_items) begin
      for (k = $urandom_range(4, 1); k > 0 && made < n_items; k--) begin
        push_add(8'($urandom_range(255)), pick_service(), pick_prio());
        made++;
      end
      for (k = $urandom_range(tick_max, 1); k > 0 && made < n_items; k--) begin
        push_tick();
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    wait (req_queue.size() == 0 && !holding && sched_expect.size() == 0);
  endtask

  // write the aging step while the block is idle, then queue a new batch
  task automatic run_phase(input logic [7:0] decr, input logic gaps,
                           input int n_items, input int tick_max);
    wait_drained();
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= decr;
    aging_step = decr;
    @(posedge clk);
    cfg_we  <= 1'b0;
    idle_on = gaps;
    queue_traffic(n_items, tick_max);
  endtask

  // driver: holds a request until start && !busy, then loads the next
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      holding  = 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        sched_expect.push_back(schedule_request(cur_req));
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0 || req_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          // idle: start low, random junk on the request fields
          start        <= 1'b0;
          mode         <= 1'($urandom_range(1));
          task_id      <= 8'($urandom_range(255));
          service_time <= 16'($urandom_range(65535));
          priority_req <= 16'($urandom_range(65535));
        end else begin
          cur_req      = req_queue.pop_front();
          holding      = 1'b1;
          start        <= 1'b1;
          mode         <= cur_req.mode;
          task_id      <= cur_req.task_id;
          service_time <= cur_req.svc;
          priority_req <= cur_req.prio;
          gap_left     = pick_gap();
        end
      end
    end
  end

  task automatic field_err(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    n_fail++;
  endtask

  // monitor: done is a one-cycle strobe, every one must match the oldest request
  always @(posedge clk) begin
    if (!rst && done) begin
      if (sched_expect.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h task %0h",
                 $time, status, ran_task);
        n_fail++;
      end else begin
        want_res = sched_expect.pop_front();
        if (status !== want_res.status) field_err("status", want_res.status, status);
        if (ran_task !== want_res.task_label)
          field_err("ran_task", want_res.task_label, ran_task);
        if (remaining !== want_res.rem) field_err("remaining", want_res.rem, remaining);
        if (finish_time !== want_res.fin)
          field_err("finish_time", want_res.fin, finish_time);
        if (turnaround !== want_res.turn)
          field_err("turnaround", want_res.turn, turnaround);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part, aging step still at its reset value
    push_tick();                              // empty table: idle tick
    push_add(8'hFF, 16'h0000, 16'sd0);        // zero service time: rejected
    push_add(8'h00, 16'hFFFF, -16'sd32768);   // long job at lowest priority
    push_add(8'hAA, 16'd2, 16'sd32767);       // top priority
    push_add(8'h55, 16'd1, 16'sd32767);       // same priority, later entry
    push_tick();                              // tie goes to the earlier entry
    push_tick();                              // requeued one now lower
    push_tick();
    // fill every remaining slot, then one more add is refused
    for (int i = 0; i < NUM_TASKS - 1; i++)
      push_add(8'(i * 17 + 1), 16'd1, pick_prio());
    push_add(8'h5A, 16'd3, 16'sd100);

    // random phases over several aging steps, extremes included
    run_phase(8'd0,   1'b1, 97, 12);
    run_phase(8'd255, 1'b1, 97, 6);
    run_phase(8'd1,   1'b0, 97, 20);
    run_phase(8'd2,   1'b1, 97, 10);
    run_phase(8'($urandom_range(255)), 1'b1, 97, 16);
    run_phase(8'd128, 1'b1, 97, 8);
    run_phase(8'd255, 1'b1, 97, 30);

    wait_drained();
    repeat (40) @(posedge clk);
    if (n_fail == 0) begin
      $display("aging_priority_task_scheduler_tb: PASS");
    end else begin
      $display("aging_priority_task_scheduler_tb: FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #1000000;
    $display("aging_priority_task_scheduler_tb: FAIL");
    $finish;
  end

endmodule
